FILE: rtl/ptdps_pkg.sv
// Shared constants for the point-to-depth pixel splat block.
// Holds register indexes, reset values and default frame size; no dependencies.
package ptdps_pkg;

    localparam int HALF_COLS_DEF = 240;
    localparam int HALF_ROWS_DEF = 100;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_PER_METER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPLAT_HALF_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPLAT_HALF_ROWS = 3'd4;

    localparam logic [15:0] VERTICAL_GAIN_RST   = 16'd8790;
    localparam logic [15:0] HORIZONTAL_GAIN_RST = 16'd11878;
    localparam logic [15:0] HUE_PER_METER_RST   = 16'd15360;
    localparam logic        SPLAT_HALF_COLS_RST = 1'b1;
    localparam logic [2:0]  SPLAT_HALF_ROWS_RST = 3'd5;
    localparam logic [2:0]  SPLAT_HALF_ROWS_MAX = 3'd5;

    localparam int SQRT_STEPS = 32;
    localparam int HUE_SEG    = 60;

    // Ramp of 255*r/60 for r below 60, which equals floor(17*r/4).
    function automatic logic [7:0] ramp(input logic [5:0] r);
        logic [9:0] p;
        p = 10'd17 * {4'd0, r};
        return p[9:2];
    endfunction

endpackage

FILE: rtl/point_to_depth_pixel_splat.sv
// Top level of the point-to-depth pixel splat block.
// Depends on ptdps_pkg for register indexes, reset values and the ramp function.
//
// Usage: each transaction on the s_axis side carries one 3-D point (point_x in
// tdata[31:0], point_y in [63:32], point_z in [95:64], signed Q15.16 meters).
// For every point inside the view the m_axis side emits one transaction per
// in-frame pixel of the splat rectangle, column-major, with tlast on the final
// pixel of the point. Dropped points and points whose splat lies entirely off
// the frame emit nothing. Registers are written through i_cfg_we, i_cfg_addr
// and i_cfg_wdata while the block is idle.
// Pipeline: a point passes 38 register stages (input, products, screen test,
// 33 square-root stages with the column and row divisions in the first QW of
// them, hue product, emitter load) on its way to its first pixel. The front
// pipeline takes a point every cycle while the emitter is idle or sending its
// last pixel. The pixel emitter sends one pixel per cycle while the receiver
// is ready and holds a point until all its in-frame pixels (up to 33) are out.
// Reset clears all valid bits and restores the register defaults. When the
// receiver stalls, the whole pipeline holds in place and s_axis tready drops.
module point_to_depth_pixel_splat #(
    parameter int HALF_COLS = ptdps_pkg::HALF_COLS_DEF,
    parameter int HALF_ROWS = ptdps_pkg::HALF_ROWS_DEF,
    localparam int CW  = $clog2(2 * HALF_COLS),
    localparam int RW  = $clog2(2 * HALF_ROWS),
    localparam int TDW = ((CW + RW + 24 + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: point_x, point_y, point_z.
    input  logic [95:0]                      i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Fields from bit 0: pixel_col, pixel_row, red, green, blue, zero fill.
    output logic [TDW-1:0]                   o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [ptdps_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ptdps_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int QCW = $clog2(2 * HALF_COLS + 1);
    localparam int QRW = $clog2(2 * HALF_ROWS + 1);
    localparam int QW  = (QCW > QRW) ? QCW : QRW;
    localparam int NW  = 44 + QW;
    localparam int NS  = ptdps_pkg::SQRT_STEPS;

    // Configuration registers.
    logic [15:0] r_vgain, r_hgain, r_hpm;
    logic        r_shc;
    logic [2:0]  r_shr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vgain <= ptdps_pkg::VERTICAL_GAIN_RST;
            r_hgain <= ptdps_pkg::HORIZONTAL_GAIN_RST;
            r_hpm   <= ptdps_pkg::HUE_PER_METER_RST;
            r_shc   <= ptdps_pkg::SPLAT_HALF_COLS_RST;
            r_shr   <= ptdps_pkg::SPLAT_HALF_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ptdps_pkg::REG_VERTICAL_GAIN:   r_vgain <= i_cfg_wdata;
                ptdps_pkg::REG_HORIZONTAL_GAIN: r_hgain <= i_cfg_wdata;
                ptdps_pkg::REG_HUE_PER_METER:   r_hpm   <= i_cfg_wdata;
                ptdps_pkg::REG_SPLAT_HALF_COLS: r_shc   <= i_cfg_wdata[0];
                ptdps_pkg::REG_SPLAT_HALF_ROWS: r_shr   <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Emitter state and the global pipeline advance.
    logic          r_busy;
    logic [QW-1:0] r_c, r_c_hi, r_r, r_r_lo, r_r_hi;
    logic [7:0]    r_red, r_green, r_blue;
    logic          w_last, w_adv;

    assign w_last = (r_c == r_c_hi) && (r_r == r_r_hi);
    assign w_adv  = !r_busy || (i_m_axis_tready && w_last);
    assign o_s_axis_tready = w_adv;

    // Stage 0: input register.
    logic               r_v0;
    logic signed [31:0] r_x0, r_y0, r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x0 <= i_s_axis_tdata[31:0];
            r_y0 <= i_s_axis_tdata[63:32];
            r_z0 <= i_s_axis_tdata[95:64];
        end
    end

    // Stage 1: gains, denominator, squares, forward test.
    logic               r_v1, r_pos1;
    logic signed [48:0] r_den1, r_gy1, r_gz1;
    logic        [63:0] r_xx1, r_yy1, r_zz1;
    logic signed [48:0] n_den1, n_gy1, n_gz1;
    logic signed [63:0] n_xx1, n_yy1, n_zz1;
    logic signed [32:0] n_ay1;

    always_comb begin
        n_den1 = {{5{r_x0[31]}}, r_x0, 12'd0};
        n_gy1  = $signed({1'b0, r_vgain}) * r_y0;
        n_gz1  = $signed({1'b0, r_hgain}) * r_z0;
        n_xx1  = r_x0 * r_x0;
        n_yy1  = r_y0 * r_y0;
        n_zz1  = r_z0 * r_z0;
        n_ay1  = r_y0[31] ? -{r_y0[31], r_y0} : {r_y0[31], r_y0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos1 <= (r_x0 > 32'sd0) && ({r_x0[31], r_x0} >= n_ay1);
            r_den1 <= n_den1;
            r_gy1  <= n_gy1;
            r_gz1  <= n_gz1;
            r_xx1  <= n_xx1;
            r_yy1  <= n_yy1;
            r_zz1  <= n_zz1;
        end
    end

    // Stage 2: screen test, numerators, squared distance.
    logic               r_v2;
    logic        [44:0] r_nc2, r_nr2;
    logic        [43:0] r_den2;
    logic        [63:0] r_sq2;
    logic signed [48:0] n_nc2, n_nr2;
    logic               n_in2;

    always_comb begin
        n_nc2 = r_den1 - r_gy1;
        n_nr2 = r_den1 - r_gz1;
        n_in2 = r_pos1 && (r_gy1 <= r_den1) && (r_gy1 >= -r_den1)
                && (r_gz1 <= r_den1) && (r_gz1 >= -r_den1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1 && n_in2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nc2  <= n_nc2[44:0];
            r_nr2  <= n_nr2[44:0];
            r_den2 <= r_den1[43:0];
            r_sq2  <= r_xx1 + r_yy1 + r_zz1;
        end
    end

    // Iterative stages: index 0 holds the scaled numerators, then one square
    // root step per stage and one quotient bit per stage for the first QW.
    logic          r_pv [0:NS];
    logic [63:0]   r_sv [0:NS];
    logic [63:0]   r_sr [0:NS];
    logic [NW-1:0] r_rc [0:NS];
    logic [NW-1:0] r_rr [0:NS];
    logic [NW-1:0] r_dn [0:NS];
    logic [QW-1:0] r_qc [0:NS];
    logic [QW-1:0] r_qr [0:NS];

    logic [63:0]   n_sv [0:NS-1];
    logic [63:0]   n_sr [0:NS-1];
    logic [NW-1:0] n_rc [0:NS-1];
    logic [NW-1:0] n_rr [0:NS-1];
    logic [QW-1:0] n_qc [0:NS-1];
    logic [QW-1:0] n_qr [0:NS-1];

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            logic [63:0]   bt, tr;
            logic [NW-1:0] ds;
            bt = 64'd1 << (62 - 2 * i);
            tr = r_sr[i] + bt;
            if (r_sv[i] >= tr) begin
                n_sv[i] = r_sv[i] - tr;
                n_sr[i] = (r_sr[i] >> 1) + bt;
            end else begin
                n_sv[i] = r_sv[i];
                n_sr[i] = r_sr[i] >> 1;
            end
            n_rc[i] = r_rc[i];
            n_rr[i] = r_rr[i];
            n_qc[i] = r_qc[i];
            n_qr[i] = r_qr[i];
            if (i < QW) begin
                ds = r_dn[i] << (QW - 1 - i);
                if (r_rc[i] >= ds) begin
                    n_rc[i] = r_rc[i] - ds;
                    n_qc[i][QW-1-i] = 1'b1;
                end
                if (r_rr[i] >= ds) begin
                    n_rr[i] = r_rr[i] - ds;
                    n_qr[i][QW-1-i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) begin
                r_pv[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_pv[0] <= r_v2;
            for (int i = 0; i < NS; i++) begin
                r_pv[i+1] <= r_pv[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sv[0] <= r_sq2;
            r_sr[0] <= 64'd0;
            r_rc[0] <= NW'(HALF_COLS) * {{(NW-45){1'b0}}, r_nc2};
            r_rr[0] <= NW'(HALF_ROWS) * {{(NW-45){1'b0}}, r_nr2};
            r_dn[0] <= {{(NW-44){1'b0}}, r_den2};
            r_qc[0] <= '0;
            r_qr[0] <= '0;
            for (int i = 0; i < NS; i++) begin
                r_sv[i+1] <= n_sv[i];
                r_sr[i+1] <= n_sr[i];
                r_rc[i+1] <= n_rc[i];
                r_rr[i+1] <= n_rr[i];
                r_dn[i+1] <= r_dn[i];
                r_qc[i+1] <= n_qc[i];
                r_qr[i+1] <= n_qr[i];
            end
        end
    end

    // Hue product stage.
    logic          r_vh;
    logic [47:0]   r_prod;
    logic [QW-1:0] r_qch, r_qrh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh <= 1'b0;
        end else if (w_adv) begin
            r_vh <= r_pv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= r_sr[NS][31:0] * r_hpm;
            r_qch  <= r_qc[NS];
            r_qrh  <= r_qr[NS];
        end
    end

    // Color and splat bounds, then load into the emitter.
    logic [23:0]   n_hue;
    logic [8:0]    n_h, n_seg;
    logic [2:0]    n_k;
    logic [7:0]    n_up, n_dn, n_red, n_green, n_blue;
    logic [2:0]    n_hr;
    logic [QW:0]   n_clo, n_chi, n_rlo, n_rhi, n_csum, n_rsum;
    logic          n_empty;

    always_comb begin
        n_hue = r_prod[47:24];
        n_h   = n_hue[8:0];
        if (n_h < 9'd60) begin
            n_k = 3'd0;
        end else if (n_h < 9'd120) begin
            n_k = 3'd1;
        end else if (n_h < 9'd180) begin
            n_k = 3'd2;
        end else if (n_h < 9'd240) begin
            n_k = 3'd3;
        end else if (n_h < 9'd300) begin
            n_k = 3'd4;
        end else begin
            n_k = 3'd5;
        end
        n_seg = n_h - 9'(ptdps_pkg::HUE_SEG * int'(n_k));
        n_up  = ptdps_pkg::ramp(n_seg[5:0]);
        n_dn  = ptdps_pkg::ramp(6'(ptdps_pkg::HUE_SEG) - n_seg[5:0]);
        n_red = 8'd0;
        n_green = 8'd0;
        n_blue = 8'd0;
        if (n_hue >= 24'd360) begin
            n_red = 8'd255;
        end else begin
            case (n_k)
                3'd0: begin n_red = 8'd255; n_green = n_up; end
                3'd1: begin n_green = 8'd255; n_red = n_dn; end
                3'd2: begin n_green = 8'd255; n_blue = n_up; end
                3'd3: begin n_blue = 8'd255; n_green = n_dn; end
                3'd4: begin n_blue = 8'd255; n_red = n_up; end
                default: begin n_red = 8'd255; n_blue = n_dn; end
            endcase
        end

        n_hr   = (r_shr > ptdps_pkg::SPLAT_HALF_ROWS_MAX) ?
                 ptdps_pkg::SPLAT_HALF_ROWS_MAX : r_shr;
        n_csum = {1'b0, r_qch} + (QW+1)'(r_shc);
        n_rsum = {1'b0, r_qrh} + (QW+1)'(n_hr);
        n_clo  = ({1'b0, r_qch} >= (QW+1)'(r_shc)) ? {1'b0, r_qch} - (QW+1)'(r_shc) : '0;
        n_rlo  = ({1'b0, r_qrh} >= (QW+1)'(n_hr)) ? {1'b0, r_qrh} - (QW+1)'(n_hr) : '0;
        n_chi  = (n_csum > (QW+1)'(2 * HALF_COLS - 1)) ? (QW+1)'(2 * HALF_COLS - 1) : n_csum;
        n_rhi  = (n_rsum > (QW+1)'(2 * HALF_ROWS - 1)) ? (QW+1)'(2 * HALF_ROWS - 1) : n_rsum;
        n_empty = (n_clo > n_chi) || (n_rlo > n_rhi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            r_busy <= r_vh && !n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c     <= n_clo[QW-1:0];
            r_c_hi  <= n_chi[QW-1:0];
            r_r     <= n_rlo[QW-1:0];
            r_r_lo  <= n_rlo[QW-1:0];
            r_r_hi  <= n_rhi[QW-1:0];
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end else if (r_busy && i_m_axis_tready) begin
            if (r_r == r_r_hi) begin
                r_r <= r_r_lo;
                r_c <= r_c + 1'b1;
            end else begin
                r_r <= r_r + 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tlast  = w_last;
    assign o_m_axis_tdata  = {{(TDW-CW-RW-24){1'b0}}, r_blue, r_green, r_red,
                              r_r[RW-1:0], r_c[CW-1:0]};

    a_col_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_c <= r_c_hi) && (r_c_hi < QW'(2 * HALF_COLS)))
        else $error("splat column beyond its run");

    a_row_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_r >= r_r_lo) && (r_r <= r_r_hi) && (r_r_hi < QW'(2 * HALF_ROWS)))
        else $error("splat row beyond its run");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_m_axis_tready |=> r_busy && $stable(r_c) && $stable(r_r))
        else $error("pixel transaction lost during stall");

    a_no_early_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_m_axis_tready && !w_last |=> r_busy)
        else $error("point released before its last pixel");

endmodule
